>>> src/snp_lbe_pkg.sv
package snp_lbe_pkg;

    localparam int NUM_LOCI     = 16;
    localparam int MAX_READ_LEN = 4096;
    localparam int RESULT_CAP   = 16;
    localparam int ACTIVE_CAP   = (NUM_LOCI < RESULT_CAP) ? NUM_LOCI : RESULT_CAP;

    localparam int POS_W    = 24;
    localparam int OFFSET_W = $clog2(MAX_READ_LEN + 1);
    localparam int SLOT_W   = 4;
    localparam int NUC_W    = 3;
    localparam int CFG_W    = 5;
    localparam int IDX_W    = (NUM_LOCI > 1) ? $clog2(NUM_LOCI) : 1;

    typedef enum logic [1:0] {
        FUNC_LOAD  = 2'd0,
        FUNC_BEGIN = 2'd1,
        FUNC_BASE  = 2'd2
    } func_t;

    localparam logic [NUC_W-1:0] NUC_GAP = 3'd0;
    localparam logic [NUC_W-1:0] NUC_A   = 3'd1;
    localparam logic [NUC_W-1:0] NUC_C   = 3'd2;
    localparam logic [NUC_W-1:0] NUC_G   = 3'd3;
    localparam logic [NUC_W-1:0] NUC_T   = 3'd4;

    localparam logic [7:0] CHAR_A = 8'h41;
    localparam logic [7:0] CHAR_C = 8'h43;
    localparam logic [7:0] CHAR_G = 8'h47;
    localparam logic [7:0] CHAR_T = 8'h54;

    typedef struct packed {
        logic [1:0]       func;
        logic [SLOT_W-1:0] locus_index;
        logic [POS_W-1:0] position;
        logic [7:0]       base;
        logic             last;
    } item_t;

    typedef struct packed {
        logic                           start;
        logic [IDX_W-1:0]               last_idx;
        logic [NUM_LOCI-1:0][NUC_W-1:0] bases;
    } emit_req_t;

    function automatic logic [NUC_W-1:0] base_code(input logic [7:0] ch);
        logic [NUC_W-1:0] code;
        unique case (ch)
            CHAR_A:  code = NUC_A;
            CHAR_C:  code = NUC_C;
            CHAR_G:  code = NUC_G;
            CHAR_T:  code = NUC_T;
            default: code = NUC_GAP;
        endcase
        return code;
    endfunction

endpackage

>>> src/snp_lbe_core.sv
module snp_lbe_core (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [snp_lbe_pkg::CFG_W-1:0]    cfg_data,
    input  logic                             item_valid,
    input  snp_lbe_pkg::item_t               item,
    output snp_lbe_pkg::emit_req_t           emit_req
);

    logic [snp_lbe_pkg::CFG_W-1:0]    loci_in_use_reg;
    logic [snp_lbe_pkg::POS_W-1:0]    locus_pos_reg [snp_lbe_pkg::NUM_LOCI];
    logic [snp_lbe_pkg::NUM_LOCI-1:0][snp_lbe_pkg::NUC_W-1:0] bases_reg, bases_next;
    logic [snp_lbe_pkg::POS_W-1:0]    read_start_reg;
    logic [snp_lbe_pkg::OFFSET_W-1:0] read_offset_reg, read_offset_next;
    logic                             any_hit_reg, any_hit_next;

    logic [snp_lbe_pkg::CFG_W-1:0]    active_n;
    logic [snp_lbe_pkg::POS_W:0]      gpos;
    logic                             in_range;
    logic [snp_lbe_pkg::NUC_W-1:0]    code;
    logic [snp_lbe_pkg::NUM_LOCI-1:0] hit_vec;
    logic                             is_base, is_begin, is_load;

    function automatic logic [snp_lbe_pkg::IDX_W-1:0] IDX_SEL(
        input logic [snp_lbe_pkg::SLOT_W-1:0] idx);
        return snp_lbe_pkg::IDX_W'(idx);
    endfunction

    assign active_n = (loci_in_use_reg > snp_lbe_pkg::CFG_W'(snp_lbe_pkg::ACTIVE_CAP))
                    ? snp_lbe_pkg::CFG_W'(snp_lbe_pkg::ACTIVE_CAP) : loci_in_use_reg;

    assign gpos = {1'b0, read_start_reg}
                + (snp_lbe_pkg::POS_W + 1)'(read_offset_reg);
    assign in_range = read_offset_reg < snp_lbe_pkg::OFFSET_W'(snp_lbe_pkg::MAX_READ_LEN);
    assign code = snp_lbe_pkg::base_code(item.base);

    always_comb
    begin
        is_load  = 1'b0;
        is_begin = 1'b0;
        is_base  = 1'b0;
        unique case (item.func)
            snp_lbe_pkg::FUNC_LOAD:  is_load  = item_valid;
            snp_lbe_pkg::FUNC_BEGIN: is_begin = item_valid;
            snp_lbe_pkg::FUNC_BASE:  is_base  = item_valid;
            default:                 is_load  = 1'b0;
        endcase
    end

    always_comb
    begin
        for (int k = 0; k < snp_lbe_pkg::NUM_LOCI; k++)
        begin
            hit_vec[k] = is_base && in_range && (code != snp_lbe_pkg::NUC_GAP)
                      && (snp_lbe_pkg::CFG_W'(k) < active_n)
                      && ({1'b0, locus_pos_reg[k]} == gpos);
        end
    end

    always_comb
    begin
        bases_next       = bases_reg;
        any_hit_next     = any_hit_reg;
        read_offset_next = read_offset_reg;
        if (is_begin)
        begin
            bases_next       = '0;
            any_hit_next     = 1'b0;
            read_offset_next = '0;
        end
        else if (is_base)
        begin
            for (int k = 0; k < snp_lbe_pkg::NUM_LOCI; k++)
            begin
                if (hit_vec[k])
                begin
                    bases_next[k] = code;
                end
            end
            any_hit_next = any_hit_reg || (|hit_vec);
            if (in_range)
            begin
                read_offset_next = read_offset_reg + 1'b1;
            end
        end
    end

    always_comb
    begin
        emit_req.start    = is_base && item.last && any_hit_next
                         && (active_n != '0);
        emit_req.last_idx = snp_lbe_pkg::IDX_W'(active_n - 1'b1);
        emit_req.bases    = bases_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            loci_in_use_reg <= '0;
            bases_reg       <= '0;
            any_hit_reg     <= 1'b0;
            read_offset_reg <= '0;
            read_start_reg  <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                loci_in_use_reg <= cfg_data;
            end
            if (is_begin)
            begin
                read_start_reg <= item.position;
            end
            if (is_base && item.last)
            begin
                bases_reg       <= '0;
                any_hit_reg     <= 1'b0;
                read_offset_reg <= '0;
            end
            else
            begin
                bases_reg       <= bases_next;
                any_hit_reg     <= any_hit_next;
                read_offset_reg <= read_offset_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (is_load && (32'(item.locus_index) < snp_lbe_pkg::NUM_LOCI))
        begin
            locus_pos_reg[IDX_SEL(item.locus_index)] <= item.position;
        end
    end

endmodule

>>> src/snp_lbe_emit.sv
module snp_lbe_emit (
    input  logic                         clk,
    input  logic                         rst_n,
    input  snp_lbe_pkg::emit_req_t       emit_req,
    output logic                         busy,
    output logic                         m_tvalid,
    input  logic                         m_tready,
    // Fields from bit 0: locus_slot (4), nucleotide (3), zero pad (1).
    output logic [7:0]                   m_tdata,
    output logic                         m_tlast
);

    logic                                                     active_reg;
    logic [snp_lbe_pkg::IDX_W-1:0]                            idx_reg;
    logic [snp_lbe_pkg::IDX_W-1:0]                            last_idx_reg;
    logic [snp_lbe_pkg::NUM_LOCI-1:0][snp_lbe_pkg::NUC_W-1:0] buf_reg;
    logic                                                     out_valid_reg;
    logic [snp_lbe_pkg::SLOT_W-1:0]                           out_slot_reg;
    logic [snp_lbe_pkg::NUC_W-1:0]                            out_nuc_reg;
    logic                                                     out_last_reg;
    logic                                                     load;
    logic                                                     final_load;

    assign load       = active_reg && (!out_valid_reg || m_tready);
    assign final_load = load && (idx_reg == last_idx_reg);
    assign busy       = active_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg    <= 1'b0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (emit_req.start)
            begin
                active_reg <= 1'b1;
                idx_reg    <= '0;
            end
            else if (load)
            begin
                if (final_load)
                begin
                    active_reg <= 1'b0;
                end
                idx_reg <= idx_reg + 1'b1;
            end
            if (load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit_req.start)
        begin
            buf_reg      <= emit_req.bases;
            last_idx_reg <= emit_req.last_idx;
        end
        if (load)
        begin
            out_slot_reg <= snp_lbe_pkg::SLOT_W'(idx_reg);
            out_nuc_reg  <= buf_reg[idx_reg];
            out_last_reg <= final_load;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, out_nuc_reg, out_slot_reg};
    assign m_tlast  = out_last_reg;

    a_start_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        emit_req.start |-> !active_reg)
        else $error("Emission request arrived while a previous one was still running.");

    a_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
        active_reg |-> (idx_reg <= last_idx_reg))
        else $error("Emission index ran past the last locus in use.");

    a_final_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (final_load && !emit_req.start) |=> (!active_reg && out_valid_reg && out_last_reg))
        else $error("Final result did not end the emission with tlast set.");

endmodule

>>> src/snp_locus_base_extractor.sv
// Locus base extractor: load locus positions with func 0, announce a read with func 1 and
// stream its bases with func 2, tlast on the final base. Each request passes through an
// input register and the match logic, so bases stream at one per cycle except while a
// last base is stalled. When a read that filled a locus ends, one result per locus in
// use leaves the output register, one per cycle while m_tready is high; a further last
// base waits at the input register until that emission has issued its final result.
module snp_locus_base_extractor (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [snp_lbe_pkg::CFG_W-1:0] cfg_data,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // Fields from bit 0: locus_index (4), position (24), base (8), zero pad (4).
    input  logic [39:0]                   s_tdata,
    // Fields from bit 0: func (2).
    input  logic [1:0]                    s_tuser,
    input  logic                          s_tlast,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // Fields from bit 0: locus_slot (4), nucleotide (3), zero pad (1).
    output logic [7:0]                    m_tdata,
    output logic                          m_tlast
);

    logic                   in_valid_reg;
    snp_lbe_pkg::item_t     item_reg;
    logic                   stall;
    logic                   advance;
    logic                   emit_busy;
    snp_lbe_pkg::emit_req_t emit_req;

    assign stall    = in_valid_reg && (item_reg.func == snp_lbe_pkg::FUNC_BASE)
                   && item_reg.last && emit_busy;
    assign advance  = in_valid_reg && !stall;
    assign s_tready = !in_valid_reg || !stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            item_reg.func        <= s_tuser;
            item_reg.locus_index <= s_tdata[3:0];
            item_reg.position    <= s_tdata[27:4];
            item_reg.base        <= s_tdata[35:28];
            item_reg.last        <= s_tlast;
        end
    end

    snp_lbe_core u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_data   (cfg_data),
        .item_valid (advance),
        .item       (item_reg),
        .emit_req   (emit_req)
    );

    snp_lbe_emit u_emit (
        .clk      (clk),
        .rst_n    (rst_n),
        .emit_req (emit_req),
        .busy     (emit_busy),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

>>> sim/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

    localparam logic [1:0] FUNC_UNUSED = 2'd3;
    localparam int CYCLE_LIMIT = 2000000;
    localparam int SETTLE_CYCLES = 40;
    localparam int IDLE_PAUSE = 20;
    localparam int PHASE_REQUESTS = 30;

    typedef struct packed {
        logic [snp_lbe_pkg::SLOT_W-1:0] slot;
        logic [snp_lbe_pkg::NUC_W-1:0]  nuc;
        logic                           eor;
    } call_t;

    logic                          clk = 1'b0;
    logic                          rst_n = 1'b0;
    logic                          cfg_we = 1'b0;
    logic [snp_lbe_pkg::CFG_W-1:0] cfg_data = '0;
    logic                          s_tvalid = 1'b0;
    logic                          s_tready;
    logic [39:0]                   s_tdata = '0;
    logic [1:0]                    s_tuser = '0;
    logic                          s_tlast = 1'b0;
    logic                          m_tvalid;
    logic                          m_tready = 1'b0;
    logic [7:0]                    m_tdata;
    logic                          m_tlast;

    snp_lbe_pkg::item_t req_queue[$];
    call_t              call_queue[$];
    snp_lbe_pkg::item_t req_on_bus;
    call_t              call_due;
    int                 send_gap = 0;
    int                 stall_left = 0;
    bit                 idling = 1'b1;
    int                 error_count = 0;
    int                 cycle_count = 0;

    logic [snp_lbe_pkg::POS_W-1:0] locus_pos [snp_lbe_pkg::NUM_LOCI];
    logic [snp_lbe_pkg::NUC_W-1:0] locus_nuc [snp_lbe_pkg::NUM_LOCI];
    logic [snp_lbe_pkg::POS_W-1:0] read_pos;
    int                            read_ofs;
    bit                            locus_hit;
    int                            loci_cfg = 0;

    snp_locus_base_extractor u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    function automatic logic [snp_lbe_pkg::NUC_W-1:0] nuc_of(input logic [7:0] ch);
        if (ch == snp_lbe_pkg::CHAR_A)
            return snp_lbe_pkg::NUC_A;
        if (ch == snp_lbe_pkg::CHAR_C)
            return snp_lbe_pkg::NUC_C;
        if (ch == snp_lbe_pkg::CHAR_G)
            return snp_lbe_pkg::NUC_G;
        if (ch == snp_lbe_pkg::CHAR_T)
            return snp_lbe_pkg::NUC_T;
        return snp_lbe_pkg::NUC_GAP;
    endfunction

    function automatic void clear_read();
        for (int k = 0; k < snp_lbe_pkg::NUM_LOCI; k++)
            locus_nuc[k] = snp_lbe_pkg::NUC_GAP;
        locus_hit = 1'b0;
        read_ofs = 0;
    endfunction

    function automatic void reset_model();
        for (int k = 0; k < snp_lbe_pkg::NUM_LOCI; k++)
            locus_pos[k] = '0;
        read_pos = '0;
        loci_cfg = 0;
        clear_read();
    endfunction

    // Applies one accepted request and queues the nucleotide calls it releases.
    function automatic void absorb_request(input snp_lbe_pkg::item_t r);
        int                            used;
        logic [snp_lbe_pkg::POS_W:0]   gpos;
        logic [snp_lbe_pkg::NUC_W-1:0] code;
        used = (loci_cfg > snp_lbe_pkg::ACTIVE_CAP) ? snp_lbe_pkg::ACTIVE_CAP : loci_cfg;
        case (r.func)
            snp_lbe_pkg::FUNC_LOAD:
            begin
                if (r.locus_index < snp_lbe_pkg::NUM_LOCI)
                    locus_pos[r.locus_index] = r.position;
            end
            snp_lbe_pkg::FUNC_BEGIN:
            begin
                read_pos = r.position;
                clear_read();
            end
            snp_lbe_pkg::FUNC_BASE:
            begin
                if (read_ofs < snp_lbe_pkg::MAX_READ_LEN)
                begin
                    gpos = {1'b0, read_pos} + (snp_lbe_pkg::POS_W + 1)'(read_ofs);
                    code = nuc_of(r.base);
                    if (code != snp_lbe_pkg::NUC_GAP)
                    begin
                        for (int k = 0; k < used; k++)
                        begin
                            if ({1'b0, locus_pos[k]} == gpos)
                            begin
                                locus_nuc[k] = code;
                                locus_hit = 1'b1;
                            end
                        end
                    end
                    read_ofs++;
                end
                if (r.last)
                begin
                    if (locus_hit)
                    begin
                        for (int k = 0; k < used; k++)
                            call_queue.insert(call_queue.size(),
                                              '{slot: k[snp_lbe_pkg::SLOT_W-1:0],
                                                nuc: locus_nuc[k],
                                                eor: (k == used - 1)});
                    end
                    clear_read();
                end
            end
            default: ;
        endcase
    endfunction

    function automatic int pick_gap();
        int r;
        if (!idling)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(6, 30);
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            send_gap <= 0;
            reset_model();
        end
        else
        begin
            if (s_tvalid && s_tready)
                absorb_request(req_on_bus);
            if (!s_tvalid || s_tready)
            begin
                if (send_gap > 0)
                begin
                    s_tvalid <= 1'b0;
                    send_gap <= send_gap - 1;
                end
                else if (req_queue.size() != 0)
                begin
                    req_on_bus = req_queue.pop_front();
                    s_tdata  <= {4'b0, req_on_bus.base, req_on_bus.position,
                                 req_on_bus.locus_index};
                    s_tuser  <= req_on_bus.func;
                    s_tlast  <= req_on_bus.last;
                    s_tvalid <= 1'b1;
                    send_gap <= pick_gap();
                end
                else
                begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
            stall_left <= 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (call_queue.size() == 0)
                begin
                    $display("%0t: unexpected result, actual slot %0d nucleotide %0d end %0b",
                             $time, m_tdata[3:0], m_tdata[6:4], m_tlast);
                    error_count++;
                end
                else
                begin
                    call_due = call_queue.pop_front();
                    if (m_tdata[3:0] !== call_due.slot)
                    begin
                        $display("%0t: locus_slot expected %0d actual %0d",
                                 $time, call_due.slot, m_tdata[3:0]);
                        error_count++;
                    end
                    if (m_tdata[6:4] !== call_due.nuc)
                    begin
                        $display("%0t: nucleotide of slot %0d expected %0d actual %0d",
                                 $time, call_due.slot, call_due.nuc, m_tdata[6:4]);
                        error_count++;
                    end
                    if (m_tlast !== call_due.eor)
                    begin
                        $display("%0t: end_of_read of slot %0d expected %0b actual %0b",
                                 $time, call_due.slot, call_due.eor, m_tlast);
                        error_count++;
                    end
                end
            end
            if (stall_left > 0)
            begin
                m_tready <= 1'b0;
                stall_left <= stall_left - 1;
            end
            else
            begin
                m_tready <= 1'b1;
                stall_left <= pick_gap();
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    function automatic void push_req(input logic [1:0] f,
                                     input logic [snp_lbe_pkg::SLOT_W-1:0] slot,
                                     input logic [snp_lbe_pkg::POS_W-1:0] p,
                                     input logic [7:0] b, input bit l);
        snp_lbe_pkg::item_t r;
        r.func = f;
        r.locus_index = slot;
        r.position = p;
        r.base = b;
        r.last = l;
        req_queue.insert(req_queue.size(), r);
    endfunction

    function automatic logic [7:0] random_base();
        case ($urandom_range(0, 9))
            0, 1:    return snp_lbe_pkg::CHAR_A;
            2, 3:    return snp_lbe_pkg::CHAR_C;
            4, 5:    return snp_lbe_pkg::CHAR_G;
            6, 7:    return snp_lbe_pkg::CHAR_T;
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic void queue_directed();
        for (int k = 0; k < snp_lbe_pkg::NUM_LOCI; k++)
        begin
            if (k == 13)
                push_req(snp_lbe_pkg::FUNC_LOAD, 4'(k), 24'd0, 8'h00, 1'b0);
            else if (k == 14)
                push_req(snp_lbe_pkg::FUNC_LOAD, 4'(k), 24'hFFFFFF, 8'h00, 1'b0);
            else if (k == 15)
                push_req(snp_lbe_pkg::FUNC_LOAD, 4'(k), 24'd203, 8'h00, 1'b0);
            else
                push_req(snp_lbe_pkg::FUNC_LOAD, 4'(k), 24'(200 + k), 8'h00, k == 3);
        end
        push_req(snp_lbe_pkg::FUNC_BEGIN, 4'd0, 24'd200, 8'h00, 1'b1);
        push_req(FUNC_UNUSED, 4'hF, 24'hFFFFFF, 8'hFF, 1'b1);
        push_req(snp_lbe_pkg::FUNC_BASE, 4'd0, 24'd0, snp_lbe_pkg::CHAR_A, 1'b0);
        push_req(snp_lbe_pkg::FUNC_BASE, 4'd0, 24'd0, snp_lbe_pkg::CHAR_C, 1'b0);
        push_req(snp_lbe_pkg::FUNC_BASE, 4'd0, 24'd0, snp_lbe_pkg::CHAR_G, 1'b0);
        push_req(snp_lbe_pkg::FUNC_BASE, 4'd0, 24'd0, snp_lbe_pkg::CHAR_T, 1'b0);
        push_req(snp_lbe_pkg::FUNC_BASE, 4'd0, 24'd0, 8'h4E, 1'b0);
        push_req(snp_lbe_pkg::FUNC_BASE, 4'd0, 24'd0, 8'h61, 1'b0);
        push_req(snp_lbe_pkg::FUNC_BASE, 4'd0, 24'd0, snp_lbe_pkg::CHAR_T, 1'b1);
        push_req(snp_lbe_pkg::FUNC_BASE, 4'd0, 24'd0, snp_lbe_pkg::CHAR_C, 1'b1);
        push_req(snp_lbe_pkg::FUNC_BEGIN, 4'd0, 24'd5000, 8'h00, 1'b0);
        push_req(snp_lbe_pkg::FUNC_BASE, 4'd0, 24'd0, snp_lbe_pkg::CHAR_A, 1'b1);
        push_req(snp_lbe_pkg::FUNC_BEGIN, 4'd0, 24'd0, 8'h00, 1'b0);
        push_req(snp_lbe_pkg::FUNC_BASE, 4'd0, 24'd0, snp_lbe_pkg::CHAR_G, 1'b1);
        push_req(snp_lbe_pkg::FUNC_BEGIN, 4'd0, 24'hFFFFFF, 8'h00, 1'b0);
        push_req(snp_lbe_pkg::FUNC_BASE, 4'd0, 24'd0, snp_lbe_pkg::CHAR_A, 1'b0);
        push_req(snp_lbe_pkg::FUNC_BASE, 4'd0, 24'd0, snp_lbe_pkg::CHAR_C, 1'b1);
    endfunction

    // Mostly complete reads around a window of loci, with some noise and abandoned reads.
    function automatic int queue_random_burst(input logic [snp_lbe_pkg::POS_W-1:0] win);
        int pushed;
        int loads;
        int len;
        bit broken;
        pushed = 0;
        if ($urandom_range(0, 99) < 12)
        begin
            case ($urandom_range(0, 3))
                0: push_req(FUNC_UNUSED, 4'($urandom), 24'($urandom), 8'($urandom),
                            1'($urandom_range(0, 1)));
                1: push_req(snp_lbe_pkg::FUNC_LOAD, 4'($urandom), 24'($urandom),
                            8'($urandom), 1'($urandom_range(0, 1)));
                2: push_req(snp_lbe_pkg::FUNC_BEGIN, 4'($urandom), 24'($urandom),
                            8'($urandom), 1'($urandom_range(0, 1)));
                default: push_req(snp_lbe_pkg::FUNC_BASE, 4'($urandom), 24'($urandom),
                                  8'($urandom), 1'($urandom_range(0, 1)));
            endcase
            return 1;
        end
        loads = $urandom_range(0, 3);
        repeat (loads)
        begin
            push_req(snp_lbe_pkg::FUNC_LOAD, 4'($urandom), 24'(win + $urandom_range(0, 40)),
                     8'($urandom), 1'($urandom_range(0, 1)));
            pushed++;
        end
        if ($urandom_range(0, 9) != 0)
        begin
            push_req(snp_lbe_pkg::FUNC_BEGIN, 4'($urandom), 24'(win + $urandom_range(0, 24)),
                     8'($urandom), 1'($urandom_range(0, 1)));
            pushed++;
        end
        len = $urandom_range(1, 24);
        broken = ($urandom_range(0, 9) == 0);
        for (int k = 0; k < len; k++)
        begin
            push_req(snp_lbe_pkg::FUNC_BASE, 4'($urandom), 24'($urandom), random_base(),
                     (k == len - 1) && !broken);
            pushed++;
        end
        return pushed;
    endfunction

    task automatic write_loci_cfg(input int v);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_data <= v[snp_lbe_pkg::CFG_W-1:0];
        loci_cfg = v;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic drain();
        while (req_queue.size() != 0 || s_tvalid || call_queue.size() != 0)
            @(posedge clk);
        repeat (IDLE_PAUSE) @(posedge clk);
    endtask

    initial
    begin
        int                            phase_cfg [6];
        logic [snp_lbe_pkg::POS_W-1:0] win;
        int                            sent;
        phase_cfg = '{31, 1, 0, 16, 7, 16};
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        write_loci_cfg(snp_lbe_pkg::ACTIVE_CAP);
        @(negedge clk);
        queue_directed();
        drain();
        for (int p = 0; p < 6; p++)
        begin
            idling = (p % 2 == 0);
            if (p == 4)
                write_loci_cfg($urandom_range(2, 15));
            else
                write_loci_cfg(phase_cfg[p]);
            if (p == 3)
                win = 24'hFFFFD8;
            else
                win = 24'($urandom_range(0, 24'hFFFF00));
            @(negedge clk);
            for (int k = 0; k < snp_lbe_pkg::NUM_LOCI; k++)
                push_req(snp_lbe_pkg::FUNC_LOAD, 4'(k), 24'(win + $urandom_range(0, 40)),
                         8'($urandom), 1'b0);
            sent = 0;
            while (sent < PHASE_REQUESTS)
                sent += queue_random_burst(win);
            drain();
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

>>> snp_locus_base_extractor.f
src/snp_lbe_pkg.sv
src/snp_lbe_core.sv
src/snp_lbe_emit.sv
src/snp_locus_base_extractor.sv
sim/tb_top.sv
